// ===== src/bdms_pkg.sv =====
package bdms_pkg;

    localparam int PC_W = 4;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LDDIV1 = 4'd1;
    localparam logic [3:0] OP_DIVSTP = 4'd2;
    localparam logic [3:0] OP_PCT    = 4'd3;
    localparam logic [3:0] OP_PCT50  = 4'd4;
    localparam logic [3:0] OP_LDDIV2 = 4'd5;
    localparam logic [3:0] OP_TARGET = 4'd6;
    localparam logic [3:0] OP_SLEW   = 4'd7;
    localparam logic [3:0] OP_LDHIGH = 4'd8;
    localparam logic [3:0] OP_EMIT   = 4'd9;

    // jump conditions
    localparam logic [2:0] C_NEXT    = 3'd0;
    localparam logic [2:0] C_ALWAYS  = 3'd1;
    localparam logic [2:0] C_NOSTART = 3'd2;
    localparam logic [2:0] C_ABSENT  = 3'd3;
    localparam logic [2:0] C_EQB     = 3'd4;
    localparam logic [2:0] C_CNTNZ   = 3'd5;
    localparam logic [2:0] C_OUTBUSY = 3'd6;

    // register indexes
    localparam logic [2:0] REG_DUTY_LOW  = 3'd0;
    localparam logic [2:0] REG_DUTY_HIGH = 3'd1;
    localparam logic [2:0] REG_REF_LOW   = 3'd2;
    localparam logic [2:0] REG_REF_HIGH  = 3'd3;
    localparam logic [2:0] REG_MAX_STEP  = 3'd4;

    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_HALF = 7'd50;
    localparam logic [2:0] DIV_CNT  = 3'd7;   // 8 steps, 2 quotient bits each

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_start;
        logic absent;
        logic eq_bounds;
        logic cnt_nz;
        logic out_busy;
    } flags_t;

    typedef struct packed {
        logic [6:0]  rem;
        logic [15:0] quo;
    } div_t;

    // microprogram
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            4'd0:    w = '{OP_NOP,    C_NOSTART, 4'd0};
            4'd1:    w = '{OP_NOP,    C_ABSENT,  4'd10};
            4'd2:    w = '{OP_LDDIV1, C_EQB,     4'd5};
            4'd3:    w = '{OP_DIVSTP, C_CNTNZ,   4'd3};
            4'd4:    w = '{OP_PCT,    C_ALWAYS,  4'd6};
            4'd5:    w = '{OP_PCT50,  C_NEXT,    4'd0};
            4'd6:    w = '{OP_LDDIV2, C_NEXT,    4'd0};
            4'd7:    w = '{OP_DIVSTP, C_CNTNZ,   4'd7};
            4'd8:    w = '{OP_TARGET, C_NEXT,    4'd0};
            4'd9:    w = '{OP_SLEW,   C_ALWAYS,  4'd11};
            4'd10:   w = '{OP_LDHIGH, C_NEXT,    4'd0};
            4'd11:   w = '{OP_NOP,    C_OUTBUSY, 4'd11};
            4'd12:   w = '{OP_EMIT,   C_ALWAYS,  4'd0};
            default: w = '{OP_NOP,    C_ALWAYS,  4'd0};
        endcase
        return w;
    endfunction

    // one restoring division step; remainder stays below den
    function automatic div_t div_step(input div_t d, input logic [6:0] den);
        div_t       r;
        logic [7:0] part;
        part = {d.rem, d.quo[15]};
        if (part >= {1'b0, den})
        begin
            r.rem = 7'(part - {1'b0, den});
            r.quo = {d.quo[14:0], 1'b1};
        end
        else
        begin
            r.rem = part[6:0];
            r.quo = {d.quo[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/blower_duty_mapper_slew_unit.sv =====
// Blower duty mapper with slew-rate limit.
// Input channel (in_valid / in_stall): one control tick per transfer, carrying
// reference (signed 9 bit), src_missing and enabled. Output channel
// (out_valid / out_stall): one duty percent per enabled tick.
// Config: APB-style writes, register i at byte address 4*i; pready is tied high.
// Registers should only be written while the unit is idle.
// Sequencing: a tick is accepted only while the microsequencer sits at step 0.
//  - disabled tick: accepted, no result, ready again the next cycle
//  - source absent: duty = duty_high, with no divider pass and no slew limit
//  - equal reference bounds: percent fixed at 50, one divider pass
//  - normal tick: both divider passes, then the slew limit
// The shared serial divider runs twice per normal tick
// (percent scaling, then the divide by 100) at 2 quotient bits per cycle.
// The next tick is taken as soon as the result is posted.
// The result sits in an output register; a stalled receiver holds it there,
// and the sequencer waits in the step before emit until the register frees up.
// Reset: registers return to their defaults, stored duty clears to zero,
// sequencer returns to step 0, output register empties.
module blower_duty_mapper_slew_unit (
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [8:0] reference,
    input  logic              src_missing,
    input  logic              enabled,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [6:0]        duty,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    bdms_pkg::ctrl_t  ctrl;
    bdms_pkg::flags_t flags;
    logic             idle;
    logic             in_xfer;
    logic             cfg_wr;

    // config registers
    logic [6:0] duty_low_reg, duty_high_reg, ref_low_reg, ref_high_reg, max_step_reg;

    // datapath registers
    logic signed [8:0] ref_reg;
    logic              absent_reg;
    logic [6:0]        rem_reg,  rem_next;
    logic [15:0]       quo_reg,  quo_next;
    logic [6:0]        den_reg,  den_next;
    logic              sign_reg, sign_next;
    logic [2:0]        cnt_reg,  cnt_next;
    logic [6:0]        pct_reg,  pct_next;
    logic [6:0]        tgt_reg,  tgt_next;
    logic [6:0]        cur_reg,  cur_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        out_duty_reg,  out_duty_next;

    // datapath temporaries
    logic signed [9:0] rdiff;
    logic [8:0]        rmag;
    logic signed [7:0] bdiff;
    logic [6:0]        bmag;
    logic signed [7:0] ddiff;
    logic [6:0]        dmag;
    logic [13:0]       dprod;
    bdms_pkg::div_t    d1, d2;
    logic [7:0]        qmag;
    logic signed [8:0] tsum;
    logic signed [8:0] sdiff;
    logic signed [8:0] step;
    logic signed [8:0] slim;
    logic signed [8:0] snew;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = !idle;
    assign in_xfer  = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign duty      = out_duty_reg;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_low_reg  <= 7'd0;
            duty_high_reg <= 7'd100;
            ref_low_reg   <= 7'd0;
            ref_high_reg  <= 7'd100;
            max_step_reg  <= 7'd20;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                bdms_pkg::REG_DUTY_LOW:  duty_low_reg  <= pwdata[6:0];
                bdms_pkg::REG_DUTY_HIGH: duty_high_reg <= pwdata[6:0];
                bdms_pkg::REG_REF_LOW:   ref_low_reg   <= pwdata[6:0];
                bdms_pkg::REG_REF_HIGH:  ref_high_reg  <= pwdata[6:0];
                bdms_pkg::REG_MAX_STEP:  max_step_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            bdms_pkg::REG_DUTY_LOW:  prdata = {25'd0, duty_low_reg};
            bdms_pkg::REG_DUTY_HIGH: prdata = {25'd0, duty_high_reg};
            bdms_pkg::REG_REF_LOW:   prdata = {25'd0, ref_low_reg};
            bdms_pkg::REG_REF_HIGH:  prdata = {25'd0, ref_high_reg};
            bdms_pkg::REG_MAX_STEP:  prdata = {25'd0, max_step_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign flags.no_start  = !(in_xfer && enabled);
    assign flags.absent    = absent_reg;
    assign flags.eq_bounds = (ref_low_reg == ref_high_reg);
    assign flags.cnt_nz    = (cnt_reg != 3'd0);
    assign flags.out_busy  = out_valid_reg && out_stall;

    bdms_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .idle  (idle)
    );

    // ---------------- datapath ----------------
    always_comb
    begin
        // first pass: |ref - ref_low| * 100 / |ref_high - ref_low|
        rdiff = {ref_reg[8], ref_reg} - $signed({3'd0, ref_low_reg});
        rmag  = rdiff[9] ? 9'(-rdiff) : rdiff[8:0];
        bdiff = $signed({1'b0, ref_high_reg}) - $signed({1'b0, ref_low_reg});
        bmag  = bdiff[7] ? 7'(-bdiff) : bdiff[6:0];
        // second pass: |duty_high - duty_low| * pct / 100
        ddiff = $signed({1'b0, duty_high_reg}) - $signed({1'b0, duty_low_reg});
        dmag  = ddiff[7] ? 7'(-ddiff) : ddiff[6:0];
        dprod = dmag * pct_reg;
        // two division steps per cycle
        d1 = bdms_pkg::div_step(bdms_pkg::div_t'({rem_reg, quo_reg}), den_reg);
        d2 = bdms_pkg::div_step(d1, den_reg);
        // floor for negative products: round magnitude up on a remainder
        qmag = {1'b0, quo_reg[6:0]} + {7'd0, sign_reg && (rem_reg != 7'd0)};
        tsum = $signed({2'd0, duty_low_reg})
             + (sign_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag}));
        // slew limit
        sdiff = $signed({2'd0, tgt_reg}) - $signed({2'd0, cur_reg});
        step  = $signed({2'd0, max_step_reg});
        if (sdiff > step)
            slim = step;
        else if (sdiff < -step)
            slim = -step;
        else
            slim = sdiff;
        snew = $signed({2'd0, cur_reg}) + slim;

        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        sign_next      = sign_reg;
        cnt_next       = cnt_reg;
        pct_next       = pct_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        out_duty_next  = out_duty_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (ctrl.op)
            bdms_pkg::OP_NOP: ;
            bdms_pkg::OP_LDDIV1:
            begin
                rem_next  = 7'd0;
                quo_next  = 16'(rmag * bdms_pkg::PCT_FULL);
                den_next  = bmag;
                sign_next = rdiff[9] ^ bdiff[7];
                cnt_next  = bdms_pkg::DIV_CNT;
            end
            bdms_pkg::OP_DIVSTP:
            begin
                rem_next = d2.rem;
                quo_next = d2.quo;
                cnt_next = cnt_reg - 3'd1;
            end
            bdms_pkg::OP_PCT:
            begin
                // negative quotient clamps to zero, large to full scale
                if (sign_reg)
                    pct_next = 7'd0;
                else if (quo_reg > {9'd0, bdms_pkg::PCT_FULL})
                    pct_next = bdms_pkg::PCT_FULL;
                else
                    pct_next = quo_reg[6:0];
            end
            bdms_pkg::OP_PCT50:
                pct_next = bdms_pkg::PCT_HALF;
            bdms_pkg::OP_LDDIV2:
            begin
                rem_next  = 7'd0;
                quo_next  = {2'd0, dprod};
                den_next  = bdms_pkg::PCT_FULL;
                sign_next = ddiff[7];
                cnt_next  = bdms_pkg::DIV_CNT;
            end
            bdms_pkg::OP_TARGET:
                tgt_next = tsum[6:0];
            bdms_pkg::OP_SLEW:
                cur_next = snew[6:0];
            bdms_pkg::OP_LDHIGH:
                cur_next = duty_high_reg;
            bdms_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_duty_next  = cur_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= 7'd0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ref_reg    <= reference;
            absent_reg <= src_missing;
        end
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        sign_reg     <= sign_next;
        pct_reg      <= pct_next;
        tgt_reg      <= tgt_next;
        out_duty_reg <= out_duty_next;
    end

`ifndef SYNTHESIS
    // an enabled tick keeps the unit busy on the following cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && enabled) |=> in_stall)
        else $error("unit not busy after enabled transfer");

    // a disabled tick leaves the unit ready
    a_idle_after_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !enabled) |=> !in_stall)
        else $error("unit busy after disabled transfer");

    // a result only appears at the end of a tick being processed
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result posted without work in progress");
`endif

endmodule

// ===== src/bdms_seq.sv =====
module bdms_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  bdms_pkg::flags_t  flags,
    output bdms_pkg::ctrl_t   ctrl,
    output logic              idle
);

    logic [bdms_pkg::PC_W-1:0] pc_reg;
    logic [bdms_pkg::PC_W-1:0] pc_next;
    logic                      jump;

    assign ctrl = bdms_pkg::ucode(pc_reg);
    assign idle = (pc_reg == '0);

    always_comb
    begin
        unique case (ctrl.cond)
            bdms_pkg::C_NEXT:    jump = 1'b0;
            bdms_pkg::C_ALWAYS:  jump = 1'b1;
            bdms_pkg::C_NOSTART: jump = flags.no_start;
            bdms_pkg::C_ABSENT:  jump = flags.absent;
            bdms_pkg::C_EQB:     jump = flags.eq_bounds;
            bdms_pkg::C_CNTNZ:   jump = flags.cnt_nz;
            bdms_pkg::C_OUTBUSY: jump = flags.out_busy;
            default:             jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Duty mapper / slew limiter bench.
// The stimulus starts with a directed plan (tick rows and register-write rows).
// Random phases follow. Each phase reprograms all five registers and then
// sends a run of random ticks.
// Every accepted tick goes through a local model of the duty math. Its
// expected duty is queued and compared in order with each output transfer.
module testbench;

    localparam int ITEMS         = 1150;
    localparam int SETTLE_CYCLES = 40;     // outlasts an unstalled tick
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int HOLD_AFTER    = 150;    // results seen before the hold-off
    localparam int PREDICT       = -1;     // row expectation comes from the model
    localparam int NO_DUTY       = -2;     // row must produce no transfer
    localparam int DIRECTED_ROWS = 26;
    localparam logic [2:0] REG_UNUSED = 3'd5;  // no register at this index

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic signed [8:0]  rd;
        logic               absent;
        logic               en;
        logic [2:0]         idx;
        logic [6:0]         val;
        logic signed [7:0]  typed;
    } plan_row_t;

    // ---------------------------------------------------------------- DUT I/O
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic signed [8:0] reference = '0;
    logic              src_missing = 1'b0;
    logic              enabled = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [6:0]        duty;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    blower_duty_mapper_slew_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .reference     (reference),
        .src_missing   (src_missing),
        .enabled       (enabled),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .duty          (duty),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // ------------------------------------------------------- model state
    // Register shadows and stored duty, kept in step with every write and
    // every accepted tick.
    logic [6:0] cfg_duty_low  = 7'd0;
    logic [6:0] cfg_duty_high = 7'd100;
    logic [6:0] cfg_ref_low   = 7'd0;
    logic [6:0] cfg_ref_high  = 7'd100;
    logic [6:0] cfg_max_step  = 7'd20;
    logic [6:0] duty_now      = 7'd0;

    logic [6:0] duty_due [$];   // expected duties, oldest first

    int  mismatches   = 0;
    int  duties_seen  = 0;
    int  ticks_sent   = 0;
    int  enabled_sent = 0;
    int  absent_sent  = 0;
    int  settings     = 0;
    bit  quiet        = 1'b0;   // phase with no gaps and no stalls
    bit  held_long    = 1'b0;

    // New duty for one tick; NO_DUTY when the tick is disabled.
    function automatic int predict_duty(input logic signed [8:0] rd, input logic ab,
                                        input logic en);
        int lo, hi, pct, num, q, tgt, step, diff;
        if (!en)
            return NO_DUTY;
        if (ab)
            duty_now = cfg_duty_high;   // jump, no slew limit
        else
        begin
            lo = int'(cfg_ref_low);
            hi = int'(cfg_ref_high);
            if (lo == hi)
                pct = int'(bdms_pkg::PCT_HALF);
            else
            begin
                // SV int division truncates toward zero, as required
                pct = ((int'(rd) - lo) * int'(bdms_pkg::PCT_FULL)) / (hi - lo);
                if (pct < 0)
                    pct = 0;
                if (pct > int'(bdms_pkg::PCT_FULL))
                    pct = int'(bdms_pkg::PCT_FULL);
            end
            // span can be negative (duty_high below duty_low): floor, not trunc
            num = (int'(cfg_duty_high) - int'(cfg_duty_low)) * pct;
            q   = num / int'(bdms_pkg::PCT_FULL);
            if ((num % int'(bdms_pkg::PCT_FULL)) != 0 && num < 0)
                q = q - 1;
            tgt  = int'(cfg_duty_low) + q;
            step = int'(cfg_max_step);
            diff = tgt - int'(duty_now);
            if (diff > step)
                diff = step;
            if (diff < -step)
                diff = -step;
            duty_now = 7'(int'(duty_now) + diff);
        end
        return int'(duty_now);
    endfunction

    function automatic plan_row_t tick(input logic signed [8:0] rd, input logic ab,
                                       input logic en, input int typed);
        return '{ROW_TICK, rd, ab, en, bdms_pkg::REG_DUTY_LOW, 7'd0, 8'(typed)};
    endfunction

    function automatic plan_row_t wr(input logic [2:0] idx, input logic [6:0] val);
        return '{ROW_WRITE, 9'sd0, 1'b0, 1'b0, idx, val, 8'(PREDICT)};
    endfunction

    // Directed plan. Typed expectations assume the reset settings
    // (duty 0..100, reference 0..100, step 20) unless a write row changed them.
    function automatic plan_row_t directed_row(input int n);
        case (n)
            0:  return tick(9'sd100,  1'b0, 1'b1, 20);       // full scale, slewed
            1:  return tick(9'sd255,  1'b0, 1'b1, 40);       // clamps at 100 pct
            2:  return tick(-9'sd256, 1'b0, 1'b1, 20);       // clamps at 0 pct
            3:  return tick(-9'sd256, 1'b1, 1'b1, 100);      // source absent
            4:  return tick(-9'sd1,   1'b0, 1'b0, NO_DUTY);  // disabled
            5:  return tick(9'sd0,    1'b0, 1'b1, 80);
            6:  return tick(9'sd255,  1'b1, 1'b0, NO_DUTY);  // disabled + absent
            7:  return tick(9'sd50,   1'b0, 1'b1, 60);
            8:  return tick(-9'sd1,   1'b0, 1'b1, 40);
            9:  return wr(bdms_pkg::REG_MAX_STEP, 7'd0);
            10: return tick(9'sd255,  1'b0, 1'b1, 40);       // zero step holds
            11: return tick(-9'sd256, 1'b1, 1'b1, 100);      // absent ignores step
            12: return wr(bdms_pkg::REG_REF_LOW, 7'd37);
            13: return wr(bdms_pkg::REG_REF_HIGH, 7'd37);
            14: return wr(bdms_pkg::REG_MAX_STEP, 7'd127);
            15: return tick(9'sd0,    1'b0, 1'b1, 50);       // equal bounds: 50 pct
            16: return wr(bdms_pkg::REG_DUTY_LOW, 7'd127);   // out of range
            17: return wr(bdms_pkg::REG_REF_LOW, 7'd100);
            18: return wr(bdms_pkg::REG_REF_HIGH, 7'd0);     // reversed bounds
            19: return tick(9'sd30,   1'b0, 1'b1, PREDICT);
            20: return tick(-9'sd200, 1'b0, 1'b1, PREDICT);
            21: return tick(9'sd255,  1'b0, 1'b1, PREDICT);
            22: return wr(REG_UNUSED, 7'd3);                 // must be ignored
            23: return wr(bdms_pkg::REG_DUTY_HIGH, 7'd0);
            default: return tick(9'sd0, 1'b1, 1'b1, 0);      // absent -> duty_high
        endcase
    endfunction

    // ------------------------------------------------------- drivers
    // Write one register; model follows at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'($urandom()), val};   // upper bits are don't-care
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bdms_pkg::REG_DUTY_LOW:  cfg_duty_low  = val;
            bdms_pkg::REG_DUTY_HIGH: cfg_duty_high = val;
            bdms_pkg::REG_REF_LOW:   cfg_ref_low   = val;
            bdms_pkg::REG_REF_HIGH:  cfg_ref_high  = val;
            bdms_pkg::REG_MAX_STEP:  cfg_max_step  = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one tick, wait for the transfer, queue what it should produce.
    task automatic send_tick(input logic signed [8:0] rd, input logic ab,
                             input logic en, input int typed);
        int gap, want;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        reference     <= rd;
        src_missing   <= ab;
        enabled       <= en;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        want = predict_duty(rd, ab, en);
        if (typed != PREDICT)
            want = typed;
        if (want >= 0)
            duty_due.push_back(7'(want));
        ticks_sent++;
        if (en)
            enabled_sent++;
        if (en && ab)
            absent_sent++;
    endtask

    // Let the unit go idle before touching registers. A disabled tick leaves
    // nothing queued, so also wait out a full tick's latency.
    task automatic settle();
        in_valid <= 1'b0;
        while (duty_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [6:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return 7'd100;
            2: return 7'd127;
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [6:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd100;
            3: return 7'd127;
            default: return 7'($urandom_range(1, 100));
        endcase
    endfunction

    // Reprogram every register. The first two phases pin the extremes.
    task automatic program_phase(input int phase);
        logic [6:0] dl, dh, rl, rh, ms;
        if (phase == 0)
        begin
            dl = 7'd127; dh = 7'd127; rl = 7'd127; rh = 7'd127; ms = 7'd127;
        end
        else if (phase == 1)
        begin
            dl = 7'd0; dh = 7'd0; rl = 7'd0; rh = 7'd0; ms = 7'd0;
        end
        else
        begin
            dl = pick_level();
            dh = pick_level();
            rl = pick_level();
            rh = ($urandom_range(0, 5) == 0) ? rl : pick_level();
            ms = pick_step();
        end
        write_reg(bdms_pkg::REG_DUTY_LOW, dl);
        write_reg(bdms_pkg::REG_DUTY_HIGH, dh);
        write_reg(bdms_pkg::REG_REF_LOW, rl);
        write_reg(bdms_pkg::REG_REF_HIGH, rh);
        write_reg(bdms_pkg::REG_MAX_STEP, ms);
        settings++;
    endtask

    // Random reading: mostly around the programmed span, sometimes anywhere
    // in the 9-bit range, sometimes pinned to the corners.
    function automatic logic signed [8:0] pick_reading();
        int lo, hi, v;
        lo = (cfg_ref_low < cfg_ref_high) ? int'(cfg_ref_low) : int'(cfg_ref_high);
        hi = (cfg_ref_low < cfg_ref_high) ? int'(cfg_ref_high) : int'(cfg_ref_low);
        case ($urandom_range(0, 3))
            0: return 9'($urandom_range(0, 511));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return -9'sd256;
                    1: return 9'sd255;
                    2: return -9'sd1;
                    default: return 9'sd0;
                endcase
            end
            default:
            begin
                v = int'($urandom_range(0, hi - lo + 40)) + lo - 20;
                return 9'(v);
            end
        endcase
    endfunction

    // ------------------------------------------------------- receiver
    // Random stall before each transfer; once, a long hold-off so the
    // output register fills and the unit pushes back on its input.
    initial
    begin
        int k;
        wait (rst_n);
        forever
        begin
            if (!held_long && duties_seen >= HOLD_AFTER)
            begin
                k = HOLD_CYCLES;
                held_long = 1'b1;
            end
            else
                k = quiet ? 0 : $urandom_range(0, 19);
            if (k > 0)
                out_stall <= 1'b1;
            repeat (k) @(posedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // ------------------------------------------------------- checker
    always @(posedge clk)
    begin
        logic [6:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            duties_seen++;
            if (duty_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] duty %0d transferred with nothing expected",
                             $realtime, duty);
            end
            else
            begin
                want = duty_due.pop_front();
                if (duty !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] duty mismatch: expected %0d, got %0d",
                                 $realtime, want, duty);
                end
            end
        end
    end

    // ------------------------------------------------------- watchdog
    // The time limit lies well above the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("** blower_duty_mapper_slew_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------- main sequence
    initial
    begin
        plan_row_t row;
        int        phase;
        int        len;
        int        w;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            row = directed_row(n);
            if (row.kind == ROW_WRITE)
            begin
                settle();
                write_reg(row.idx, row.val);
            end
            else
                send_tick(row.rd, row.absent, row.en, int'(row.typed));
        end

        // random phases; every third one runs flat out
        phase = 0;
        while (ticks_sent < ITEMS)
        begin
            settle();
            program_phase(phase);
            quiet = (phase % 3 == 2);
            len = $urandom_range(60, 120);
            repeat (len)
                send_tick(pick_reading(), ($urandom_range(0, 9) == 0),
                          ($urandom_range(0, 7) != 0), PREDICT);
            phase++;
        end

        // drain, bounded; anything still queued is a miss
        in_valid <= 1'b0;
        quiet = 1'b0;
        for (w = 0; w < DRAIN_LIMIT && duty_due.size() != 0; w++)
            @(posedge clk);
        if (duty_due.size() != 0)
        begin
            $display("%0d expected duties never transferred", duty_due.size());
            mismatches += duty_due.size();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d ticks (%0d enabled, %0d with source absent) over %0d settings;",
                 ticks_sent, enabled_sent, absent_sent, settings);
        $display("checked %0d duty transfers, %0d mismatches.", duties_seen, mismatches);
        if (mismatches == 0)
            $display("** blower_duty_mapper_slew_unit: PASSED **");
        else
            $display("** blower_duty_mapper_slew_unit: FAILED **");
        $finish;
    end

endmodule
